// File: rtl/fwrm_pkg.sv
// Package: constants and types shared by the flow window rate meter.
package fwrm_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int PENDING_DEPTH = 256;
    localparam int KEY_BITS      = 64;

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int PEND_W = $clog2(PENDING_DEPTH);
    localparam int PTR_W  = PEND_W + 1;
    localparam int REF_W  = PEND_W + 1;
    localparam int PEND_DATA_W = SLOT_W + 16 + 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd1;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CROSSED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] flow_key;
        logic [15:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] flow_count;
    } t_out_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [15:0]       amount;
        logic [31:0]       due;
    } t_pend;

    // Search request and result between sequencer and search unit.
    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] key;
    } t_srch_req;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free_ok;
        logic [SLOT_W-1:0] free_slot;
    } t_srch_rsp;
endpackage

// File: rtl/fwrm_if.sv
// Valid/ready channel interface carrying one payload.
interface fwrm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fwrm_ram.sv
// Generic single-port RAM with registered read.
module fwrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: rtl/fwrm_search.sv
// Key search unit: walks the table one slot a cycle with one shared comparator.
module fwrm_search import fwrm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_srch_req                i_req,
    input  logic [TABLE_ENTRIES-1:0] i_valid,
    input  logic [TABLE_ENTRIES-1:0] i_refd,
    output logic [SLOT_W-1:0]        o_key_addr,
    input  logic [KEY_BITS-1:0]      i_key_rdata,
    output t_srch_rsp                o_rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W:0]   r_idx, n_idx;
    logic [SLOT_W-1:0] r_cmp_slot, n_cmp_slot;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_hit, n_hit;
    logic [SLOT_W-1:0] r_hit_slot, n_hit_slot;
    logic              r_free_ok, n_free_ok;
    logic [SLOT_W-1:0] r_free_slot, n_free_slot;
    logic [KEY_BITS-1:0] r_key;
    logic              cur_in_range;
    logic [SLOT_W-1:0] cur_slot;

    assign cur_slot     = r_idx[SLOT_W-1:0];
    assign cur_in_range = (r_idx < (SLOT_W+1)'(TABLE_ENTRIES));
    assign o_key_addr   = cur_slot;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmp_slot  = r_cmp_slot;
        n_cmp_vld   = 1'b0;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_free_ok   = r_free_ok;
        n_free_slot = r_free_slot;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state   = S_RUN;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                end
            end
            S_RUN: begin
                // key read data arrives in the cycle after its address
                if (r_cmp_vld && !r_hit && i_valid[r_cmp_slot]
                        && i_key_rdata == r_key) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_cmp_slot;
                end
                if (cur_in_range) begin
                    if (!r_free_ok && !i_valid[cur_slot] && !i_refd[cur_slot]) begin
                        n_free_ok   = 1'b1;
                        n_free_slot = cur_slot;
                    end
                    n_cmp_slot = cur_slot;
                    n_cmp_vld  = 1'b1;
                    n_idx      = r_idx + 1'b1;
                end else if (!r_cmp_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
        end
        r_idx       <= n_idx;
        r_cmp_slot  <= n_cmp_slot;
        r_hit       <= n_hit;
        r_hit_slot  <= n_hit_slot;
        r_free_ok   <= n_free_ok;
        r_free_slot <= n_free_slot;
        if (r_state == S_IDLE && i_req.start) begin
            r_key <= i_req.key;
        end
    end

    assign o_rsp.done      = (r_state == S_DONE);
    assign o_rsp.hit       = r_hit;
    assign o_rsp.hit_slot  = r_hit_slot;
    assign o_rsp.free_ok   = r_free_ok;
    assign o_rsp.free_slot = r_free_slot;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> $past(r_state) == S_RUN)
        else $error("search done without run");
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && $rose(r_hit)) |-> $past(i_valid[r_cmp_slot]))
        else $error("search hit on invalid slot");
    a_free_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && $rose(r_free_ok)) |-> $past(!i_refd[cur_slot]))
        else $error("free slot still referenced");
endmodule

// File: rtl/flow_window_rate_meter_core.sv
// Top level: flow window rate meter with sequencer, table and pending queue.
// Each beat is handled alone; ready is low while it is processed. The key
// search sets this time for an add or a query: it reads one table key per
// cycle, and the key RAM read is registered. A tick drains each expired
// decrement in turn. Each drain reads the queue, then the slot's count and
// reference RAMs, in turn. A result waits in an output register until it is
// taken. The next beat is accepted meanwhile, and a later result waits in
// S_OUT until the register is free.
module flow_window_rate_meter_core import fwrm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fwrm_if.sink                  in_ch,
    fwrm_if.source                out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_WAIT   = 4'd2;
    localparam logic [3:0] S_CRD    = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_OUT    = 4'd5;
    localparam logic [3:0] S_TCHK   = 4'd6;
    localparam logic [3:0] S_TRD    = 4'd7;
    localparam logic [3:0] S_TCRD   = 4'd8;
    localparam logic [3:0] S_TSUB   = 4'd9;
    localparam logic [3:0] S_CRD2   = 4'd10;
    localparam logic [3:0] S_TRD2   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [31:0] r_threshold;
    logic [19:0] r_window;
    logic [31:0] r_now;
    logic [PTR_W-1:0] r_head, r_tail;
    logic [TABLE_ENTRIES-1:0] r_valid, r_alarm;
    // a slot is referenced while queued decrements still point at it
    logic [TABLE_ENTRIES-1:0] r_refd;
    logic [REF_W-1:0] r_ref;
    t_in_item  r_item;
    t_out_item r_res;
    t_out_item r_out;
    logic r_out_vld;
    logic [SLOT_W-1:0] r_slot;
    logic [31:0] r_cnt;
    t_pend r_pend;

    // RAM ports
    logic              key_we;
    logic [SLOT_W-1:0] key_addr, srch_key_addr;
    logic [KEY_BITS-1:0] key_rdata;
    logic              cnt_we;
    logic [SLOT_W-1:0] cnt_addr;
    logic [31:0]       cnt_wdata, cnt_rdata;
    logic              refs_we;
    logic [REF_W-1:0]  refs_wdata, refs_rdata;
    logic              pq_we;
    logic [PEND_W-1:0] pq_addr;
    logic [PEND_DATA_W-1:0] pq_wdata, pq_rdata;
    t_pend pq_rd;

    t_srch_req srch_req;
    t_srch_rsp srch_rsp;

    logic [PTR_W-1:0] occ;
    logic q_full, q_empty;
    logic out_free;
    logic [32:0] add_sum;
    logic [31:0] add_sat, sub_res, due_diff;

    assign occ     = r_tail - r_head;
    assign q_full  = (occ >= PTR_W'(PENDING_DEPTH));
    assign q_empty = (occ == '0);
    assign pq_rd   = t_pend'(pq_rdata);
    assign add_sum = {1'b0, r_cnt} + {17'd0, r_item.amount};
    assign add_sat = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
    // count for the drained slot arrives from the RAM in S_TSUB's cycle
    assign sub_res = (cnt_rdata > {16'd0, r_pend.amount})
                     ? cnt_rdata - {16'd0, r_pend.amount} : 32'd0;
    assign due_diff = r_now - pq_rd.due;
    assign out_free = !r_out_vld || out_ch.ready;

    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = r_out_vld;
    assign out_ch.data  = r_out;

    assign srch_req.start = (r_state == S_SRCH);
    assign srch_req.key   = r_item.flow_key[KEY_BITS-1:0];

    fwrm_search u_search (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(srch_req), .i_valid(r_valid),
        .i_refd(r_refd), .o_key_addr(srch_key_addr), .i_key_rdata(key_rdata),
        .o_rsp(srch_rsp)
    );

    fwrm_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_addr(key_addr),
        .i_wdata(r_item.flow_key[KEY_BITS-1:0]), .o_rdata(key_rdata)
    );
    fwrm_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_counts (
        .i_clk(i_clk), .i_we(cnt_we), .i_addr(cnt_addr),
        .i_wdata(cnt_wdata), .o_rdata(cnt_rdata)
    );
    fwrm_ram #(.WIDTH(REF_W), .DEPTH(TABLE_ENTRIES)) u_refs (
        .i_clk(i_clk), .i_we(refs_we), .i_addr(cnt_addr),
        .i_wdata(refs_wdata), .o_rdata(refs_rdata)
    );
    fwrm_ram #(.WIDTH(PEND_DATA_W), .DEPTH(PENDING_DEPTH)) u_pend (
        .i_clk(i_clk), .i_we(pq_we), .i_addr(pq_addr),
        .i_wdata(pq_wdata), .o_rdata(pq_rdata)
    );

    always_comb begin
        key_we     = (r_state == S_ADD) && !r_valid[r_slot];
        key_addr   = (r_state == S_ADD) ? r_slot : srch_key_addr;
        cnt_we     = 1'b0;
        cnt_addr   = r_slot;
        cnt_wdata  = add_sat;
        refs_we    = 1'b0;
        refs_wdata = r_ref + 1'b1;
        pq_we      = 1'b0;
        pq_addr    = r_head[PEND_W-1:0];
        pq_wdata   = {r_slot, r_item.amount, r_now + {12'd0, r_window}};
        case (r_state)
            S_CRD: cnt_addr = srch_rsp.hit ? srch_rsp.hit_slot : srch_rsp.free_slot;
            S_ADD: begin
                cnt_we  = 1'b1;
                refs_we = 1'b1;
                pq_we   = 1'b1;
                pq_addr = r_tail[PEND_W-1:0];
            end
            S_TCRD: cnt_addr = pq_rd.slot;
            S_TSUB: begin
                cnt_we     = r_valid[r_slot];
                cnt_wdata  = sub_res;
                refs_we    = 1'b1;
                refs_wdata = refs_rdata - 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    case (in_ch.data.kind)
                        KIND_ADD, KIND_QUERY: n_state = S_SRCH;
                        KIND_TICK:            n_state = S_TCHK;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH: n_state = S_WAIT;
            S_WAIT: if (srch_rsp.done) n_state = S_CRD;
            S_CRD:  n_state = S_CRD2;
            S_CRD2: n_state = (r_item.kind == KIND_ADD && !q_full
                               && (srch_rsp.hit || srch_rsp.free_ok)) ? S_ADD : S_OUT;
            S_ADD:  n_state = S_OUT;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            S_TCHK: n_state = q_empty ? S_IDLE : S_TRD;
            S_TRD:  n_state = S_TRD2;
            S_TRD2: n_state = due_diff[31] ? S_IDLE : S_TCRD;
            S_TCRD: n_state = S_TSUB;
            S_TSUB: n_state = S_TCHK;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= 32'd0;
            r_window    <= 20'd1000;
            r_now       <= 32'd0;
            r_head      <= '0;
            r_tail      <= '0;
            r_valid     <= '0;
            r_alarm     <= '0;
            r_refd      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESHOLD:    r_threshold <= i_cfg_data;
                    REG_WINDOW_TICKS: r_window    <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_out     <= r_res;
                r_out_vld <= 1'b1;
            end else if (out_ch.valid && out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == S_IDLE && in_ch.valid && in_ch.ready) begin
                r_item <= in_ch.data;
                if (in_ch.data.kind == KIND_TICK) begin
                    r_now <= r_now + 32'd1;
                end
            end
            case (r_state)
                S_CRD: begin
                    r_slot <= srch_rsp.hit ? srch_rsp.hit_slot : srch_rsp.free_slot;
                end
                S_CRD2: begin
                    r_cnt <= srch_rsp.hit ? cnt_rdata : 32'd0;
                    r_ref <= r_refd[r_slot] ? refs_rdata : '0;
                    r_res.found      <= srch_rsp.hit;
                    r_res.flow_count <= srch_rsp.hit ? cnt_rdata : 32'd0;
                    r_res.status     <= (r_item.kind == KIND_ADD) ? ST_DROPPED : ST_OK;
                end
                S_ADD: begin
                    r_valid[r_slot]  <= 1'b1;
                    r_refd[r_slot]   <= 1'b1;
                    r_res.found      <= 1'b1;
                    r_res.flow_count <= add_sat;
                    r_tail           <= r_tail + 1'b1;
                    if (r_threshold != 32'd0 && add_sat > r_threshold
                            && !(r_alarm[r_slot] && r_valid[r_slot])) begin
                        r_alarm[r_slot] <= 1'b1;
                        r_res.status    <= ST_CROSSED;
                    end else begin
                        r_alarm[r_slot] <= r_valid[r_slot] && r_alarm[r_slot];
                        r_res.status    <= ST_OK;
                    end
                end
                S_TRD2: r_pend <= pq_rd;
                S_TCRD: r_slot <= r_pend.slot;
                S_TSUB: begin
                    r_refd[r_slot] <= (refs_rdata != REF_W'(1));
                    r_head <= r_head + 1'b1;
                    if (r_valid[r_slot]) begin
                        r_alarm[r_slot] <= 1'b0;
                        if (sub_res == 32'd0) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready)
        else $error("accepted beat while busy");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= PTR_W'(PENDING_DEPTH))
        else $error("pending queue overflow");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_vld)
        else $error("result lost");
endmodule
